// ===== hdl/segment_length_and_angle_top_assert.svh =====
// assertion macros for the segment length and angle block
// used by the port checker, needs nothing else
`ifndef SEGMENT_LENGTH_AND_ANGLE_TOP_ASSERT_SVH
`define SEGMENT_LENGTH_AND_ANGLE_TOP_ASSERT_SVH

// plain clocked property, off during reset
`define SLA_ASSERT(label, clk_sig, rst_sig, prop, msg) \
    label: assert property (@(posedge clk_sig) disable iff (!rst_sig) (prop)) else $error(msg);

// antecedent in this cycle, consequent in the next
`define SLA_ASSERT_NEXT(label, clk_sig, rst_sig, ante, cons, msg) \
    `SLA_ASSERT(label, clk_sig, rst_sig, (ante) |=> (cons), msg)

`endif

// ===== hdl/sla_pkg.sv =====
// shared types, widths and tables for the segment length and angle block
// no dependencies
package sla_pkg;

    localparam int ROTATION_STEPS = 16;
    localparam int ATAN_STEPS_MAX = 24;
    localparam int CORDIC_STEPS   = (ROTATION_STEPS < ATAN_STEPS_MAX) ?
                                    ROTATION_STEPS : ATAN_STEPS_MAX;
    localparam int SQRT_BITS      = 17;
    localparam int NUM_CELLS      = (CORDIC_STEPS > SQRT_BITS) ? CORDIC_STEPS : SQRT_BITS;
    localparam int CELL_IDX_W     = $clog2(NUM_CELLS);
    localparam int ATAN_IDX_W     = $clog2(ATAN_STEPS_MAX);
    localparam int BIT_POS_W      = $clog2(SQRT_BITS);

    localparam int COORD_W  = 16;
    localparam int DIFF_W   = COORD_W + 1;
    localparam int SQ_W     = 32;
    localparam int REM_W    = SQ_W + 1;
    localparam int TRIAL_W  = REM_W + 2;
    localparam int LEN_W    = 17;
    localparam int ANGLE_W  = 16;
    localparam int XY_W     = 32;
    localparam int Z_W      = 20;

    localparam int CORDIC_PRESHIFT = 12;
    localparam int HALF_PI_Q16     = 102944;
    localparam int PI_Q13          = 25736;
    localparam int Z_ROUND_BIAS    = 4;
    localparam int Z_ROUND_SHIFT   = 3;

    typedef struct packed {
        logic signed [XY_W-1:0] x;
        logic signed [XY_W-1:0] y;
        logic signed [Z_W-1:0]  z;
        logic [REM_W-1:0]       rem;
        logic [LEN_W-1:0]       root;
        logic                   zero_vec;
        logic                   neg_axis;
        logic                   last;
    } cell_data_t;

    // atan(2^-i) in units of 2^-16 rad, rounded
    function automatic logic signed [Z_W-1:0] atan_q16(input logic [ATAN_IDX_W-1:0] idx);
        logic signed [Z_W-1:0] val;
        case (idx)
            5'd0:    val = Z_W'(51472);
            5'd1:    val = Z_W'(30386);
            5'd2:    val = Z_W'(16055);
            5'd3:    val = Z_W'(8150);
            5'd4:    val = Z_W'(4091);
            5'd5:    val = Z_W'(2047);
            5'd6:    val = Z_W'(1024);
            5'd7:    val = Z_W'(512);
            5'd8:    val = Z_W'(256);
            5'd9:    val = Z_W'(128);
            5'd10:   val = Z_W'(64);
            5'd11:   val = Z_W'(32);
            5'd12:   val = Z_W'(16);
            5'd13:   val = Z_W'(8);
            5'd14:   val = Z_W'(4);
            5'd15:   val = Z_W'(2);
            5'd16:   val = Z_W'(1);
            5'd17:   val = Z_W'(1);
            default: val = '0;
        endcase
        return val;
    endfunction

endpackage

// ===== hdl/sla_cell.sv =====
// one cell of the chain: up to one cordic vectoring step and one square root bit
// depends on sla_pkg
module sla_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic [sla_pkg::CELL_IDX_W-1:0]  step,
    input  logic                            in_valid,
    output logic                            in_ready,
    input  sla_pkg::cell_data_t             in_data,
    output logic                            out_valid,
    input  logic                            out_ready,
    output sla_pkg::cell_data_t             out_data
);

    logic                valid_reg;
    sla_pkg::cell_data_t data_reg;
    sla_pkg::cell_data_t data_next;

    logic                                  cordic_en;
    logic                                  sqrt_en;
    logic signed [sla_pkg::XY_W-1:0]       xs;
    logic signed [sla_pkg::XY_W-1:0]       ys;
    logic signed [sla_pkg::Z_W-1:0]        atan_val;
    logic [sla_pkg::BIT_POS_W-1:0]         bit_pos;
    logic [sla_pkg::TRIAL_W-1:0]           trial;
    logic [sla_pkg::TRIAL_W-1:0]           rem_ext;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_data  = data_reg;

    assign cordic_en = step < sla_pkg::CELL_IDX_W'(sla_pkg::CORDIC_STEPS);
    assign sqrt_en   = step < sla_pkg::CELL_IDX_W'(sla_pkg::SQRT_BITS);
    assign xs        = in_data.x >>> step;
    assign ys        = in_data.y >>> step;
    assign atan_val  = sla_pkg::atan_q16(sla_pkg::ATAN_IDX_W'(step));
    // result bit handled here, counted down from the top
    assign bit_pos   = sla_pkg::BIT_POS_W'(sla_pkg::SQRT_BITS - 1) -
                       sla_pkg::BIT_POS_W'(step);
    // (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
    assign trial     = (sla_pkg::TRIAL_W'(in_data.root) << (bit_pos + 1'b1)) +
                       (sla_pkg::TRIAL_W'(1) << {bit_pos, 1'b0});
    assign rem_ext   = sla_pkg::TRIAL_W'(in_data.rem);

    always_comb
    begin
        data_next = in_data;
        if (cordic_en)
        begin
            if (!in_data.y[sla_pkg::XY_W-1])
            begin
                data_next.x = in_data.x + ys;
                data_next.y = in_data.y - xs;
                data_next.z = in_data.z + atan_val;
            end
            else
            begin
                data_next.x = in_data.x - ys;
                data_next.y = in_data.y + xs;
                data_next.z = in_data.z - atan_val;
            end
        end
        if (sqrt_en && (rem_ext >= trial))
        begin
            data_next.rem  = in_data.rem - trial[sla_pkg::REM_W-1:0];
            data_next.root = in_data.root | (sla_pkg::LEN_W'(1) << bit_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= data_next;
        end
    end

endmodule

// ===== hdl/sla_front.sv =====
// front stages: differences, squares, quadrant fold and sum of squares
// depends on sla_pkg
module sla_front (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [sla_pkg::COORD_W-1:0]  start_x,
    input  logic signed [sla_pkg::COORD_W-1:0]  start_y,
    input  logic signed [sla_pkg::COORD_W-1:0]  end_x,
    input  logic signed [sla_pkg::COORD_W-1:0]  end_y,
    input  logic                                last_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output sla_pkg::cell_data_t                 out_data
);

    // stage 1: differences
    logic                               v1_reg;
    logic signed [sla_pkg::DIFF_W-1:0]  dx_reg;
    logic signed [sla_pkg::DIFF_W-1:0]  dy_reg;
    logic                               last1_reg;
    logic signed [sla_pkg::DIFF_W-1:0]  dx_next;
    logic signed [sla_pkg::DIFF_W-1:0]  dy_next;

    // stage 2: squares and folded vector
    logic                                  v2_reg;
    logic [sla_pkg::SQ_W-1:0]              sqx_reg;
    logic [sla_pkg::SQ_W-1:0]              sqy_reg;
    sla_pkg::cell_data_t                   s2_reg;
    logic signed [2*sla_pkg::DIFF_W-1:0]   sqx_full;
    logic signed [2*sla_pkg::DIFF_W-1:0]   sqy_full;
    logic signed [sla_pkg::XY_W-1:0]       dxw;
    logic signed [sla_pkg::XY_W-1:0]       dyw;
    sla_pkg::cell_data_t                   s2_next;

    // stage 3: sum of squares
    logic                v3_reg;
    sla_pkg::cell_data_t s3_reg;
    sla_pkg::cell_data_t s3_next;

    logic r1;
    logic r2;
    logic r3;

    assign r3        = !v3_reg || out_ready;
    assign r2        = !v2_reg || r3;
    assign r1        = !v1_reg || r2;
    assign in_ready  = r1;
    assign out_valid = v3_reg;
    assign out_data  = s3_reg;

    assign dx_next  = sla_pkg::DIFF_W'(end_x) - sla_pkg::DIFF_W'(start_x);
    assign dy_next  = sla_pkg::DIFF_W'(end_y) - sla_pkg::DIFF_W'(start_y);

    assign sqx_full = dx_reg * dx_reg;
    assign sqy_full = dy_reg * dy_reg;
    assign dxw      = sla_pkg::XY_W'(dx_reg) <<< sla_pkg::CORDIC_PRESHIFT;
    assign dyw      = sla_pkg::XY_W'(dy_reg) <<< sla_pkg::CORDIC_PRESHIFT;

    always_comb
    begin
        s2_next          = '0;
        s2_next.last     = last1_reg;
        s2_next.zero_vec = (dx_reg == '0) && (dy_reg == '0);
        s2_next.neg_axis = (dy_reg == '0) && dx_reg[sla_pkg::DIFF_W-1];
        // fold the left half plane onto the right by a quarter turn
        if (!dx_reg[sla_pkg::DIFF_W-1])
        begin
            s2_next.x = dxw;
            s2_next.y = dyw;
            s2_next.z = '0;
        end
        else if (!dy_reg[sla_pkg::DIFF_W-1])
        begin
            s2_next.x = dyw;
            s2_next.y = -dxw;
            s2_next.z = sla_pkg::Z_W'(sla_pkg::HALF_PI_Q16);
        end
        else
        begin
            s2_next.x = -dyw;
            s2_next.y = dxw;
            s2_next.z = -sla_pkg::Z_W'(sla_pkg::HALF_PI_Q16);
        end
    end

    always_comb
    begin
        s3_next      = s2_reg;
        s3_next.rem  = sla_pkg::REM_W'(sqx_reg) + sla_pkg::REM_W'(sqy_reg);
        s3_next.root = '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            if (r1)
            begin
                v1_reg <= in_valid;
            end
            if (r2)
            begin
                v2_reg <= v1_reg;
            end
            if (r3)
            begin
                v3_reg <= v2_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && r1)
        begin
            dx_reg    <= dx_next;
            dy_reg    <= dy_next;
            last1_reg <= last_in;
        end
        if (v1_reg && r2)
        begin
            sqx_reg <= sqx_full[sla_pkg::SQ_W-1:0];
            sqy_reg <= sqy_full[sla_pkg::SQ_W-1:0];
            s2_reg  <= s2_next;
        end
        if (v2_reg && r3)
        begin
            s3_reg <= s3_next;
        end
    end

endmodule

// ===== hdl/sla_tail.sv =====
// output register: length rounding, angle scaling and clamping
// depends on sla_pkg
module sla_tail (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  sla_pkg::cell_data_t                 in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sla_pkg::LEN_W-1:0]           length,
    output logic signed [sla_pkg::ANGLE_W-1:0]  angle,
    output logic                                last_out
);

    logic                               valid_reg;
    logic [sla_pkg::LEN_W-1:0]          length_reg;
    logic signed [sla_pkg::ANGLE_W-1:0] angle_reg;
    logic                               last_reg;

    logic [sla_pkg::LEN_W-1:0]          length_next;
    logic signed [sla_pkg::ANGLE_W-1:0] angle_next;
    logic                               round_up;
    logic signed [sla_pkg::Z_W:0]       z_bias;
    logic signed [sla_pkg::Z_W:0]       z_shift;
    logic signed [sla_pkg::Z_W:0]       pi_lim;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign length    = length_reg;
    assign angle     = angle_reg;
    assign last_out  = last_reg;

    // remainder above root means the value is past root + 1/2
    assign round_up    = in_data.rem > sla_pkg::REM_W'(in_data.root);
    assign length_next = in_data.root + sla_pkg::LEN_W'(round_up);

    assign pi_lim  = (sla_pkg::Z_W+1)'(sla_pkg::PI_Q13);
    assign z_bias  = (sla_pkg::Z_W+1)'(in_data.z) +
                     (sla_pkg::Z_W+1)'(sla_pkg::Z_ROUND_BIAS);
    assign z_shift = z_bias >>> sla_pkg::Z_ROUND_SHIFT;

    always_comb
    begin
        if (in_data.zero_vec)
        begin
            angle_next = '0;
        end
        else if (in_data.neg_axis)
        begin
            angle_next = sla_pkg::ANGLE_W'(sla_pkg::PI_Q13);
        end
        else if (z_shift > pi_lim)
        begin
            angle_next = sla_pkg::ANGLE_W'(sla_pkg::PI_Q13);
        end
        else if (z_shift < -pi_lim)
        begin
            angle_next = -sla_pkg::ANGLE_W'(sla_pkg::PI_Q13);
        end
        else
        begin
            angle_next = z_shift[sla_pkg::ANGLE_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            length_reg <= length_next;
            angle_reg  <= angle_next;
            last_reg   <= in_data.last;
        end
    end

endmodule

// ===== hdl/segment_length_and_angle_top.sv =====
// segment length and angle: top level, front stages, cell chain, output register
// depends on sla_pkg, sla_front, sla_cell, sla_tail
//
// Input channel (in_valid/in_ready) carries one segment per transaction: start and
// end points in signed Q8.8 and a last flag. Output channel (out_valid/out_ready)
// returns one transaction per segment: length in unsigned Q9.8 rounded to nearest,
// angle atan2(dy,dx) in signed Q3.13 radians, and the copied last flag.
// A zero vector gives angle 0, the negative x axis gives +pi.
// The pipeline is three front stages, one chain cell per square root bit or cordic
// step, and one output register. Each cell does at most one cordic step and one root
// bit, so a new segment is accepted every cycle while the receiver does not stall.
// Every stage has its own valid bit; a stage takes new data when it is empty or
// its successor moves, so bubbles are squeezed out while the receiver stalls and
// input is held off only once every stage is full.
// Reset clears all valid bits; the block is ready as soon as reset is released.
module segment_length_and_angle_top (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [sla_pkg::COORD_W-1:0]  start_x,
    input  logic signed [sla_pkg::COORD_W-1:0]  start_y,
    input  logic signed [sla_pkg::COORD_W-1:0]  end_x,
    input  logic signed [sla_pkg::COORD_W-1:0]  end_y,
    input  logic                                last_in,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [sla_pkg::LEN_W-1:0]           length,
    output logic signed [sla_pkg::ANGLE_W-1:0]  angle,
    output logic                                last_out
);

    sla_pkg::cell_data_t chain_data  [sla_pkg::NUM_CELLS+1];
    logic                chain_valid [sla_pkg::NUM_CELLS+1];
    logic                chain_ready [sla_pkg::NUM_CELLS+1];

    sla_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .last_in   (last_in),
        .out_valid (chain_valid[0]),
        .out_ready (chain_ready[0]),
        .out_data  (chain_data[0])
    );

    for (genvar i = 0; i < sla_pkg::NUM_CELLS; i++)
    begin : g_cell
        sla_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .step      (sla_pkg::CELL_IDX_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_ready  (chain_ready[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_ready (chain_ready[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    sla_tail u_tail (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (chain_valid[sla_pkg::NUM_CELLS]),
        .in_ready  (chain_ready[sla_pkg::NUM_CELLS]),
        .in_data   (chain_data[sla_pkg::NUM_CELLS]),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .length    (length),
        .angle     (angle),
        .last_out  (last_out)
    );

endmodule

// ===== hdl/sla_checker.sv =====
// port checker for the segment length and angle block, bound to the top level
// depends on sla_pkg and segment_length_and_angle_top_assert.svh
`include "segment_length_and_angle_top_assert.svh"

module sla_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_ready,
    input  logic                                out_valid,
    input  logic                                out_ready,
    input  logic [sla_pkg::LEN_W-1:0]           length,
    input  logic signed [sla_pkg::ANGLE_W-1:0]  angle,
    input  logic                                last_out
);

    // a stalled result transaction stays offered
    `SLA_ASSERT_NEXT(a_out_valid_hold, clk, rst_n, out_valid && !out_ready, out_valid, "out_valid dropped while stalled")

    // and its payload holds
    `SLA_ASSERT_NEXT(a_out_data_hold, clk, rst_n, out_valid && !out_ready, $stable(length) && $stable(angle) && $stable(last_out), "result changed while stalled")

    // an empty output register means the whole pipeline can move
    `SLA_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready, "input stalled with empty output")

    `SLA_ASSERT(a_angle_range, clk, rst_n, out_valid |-> (int'(angle) <= sla_pkg::PI_Q13 && int'(angle) >= -sla_pkg::PI_Q13), "angle outside +-pi")

    // only a zero vector rounds to zero length
    `SLA_ASSERT(a_zero_length_angle, clk, rst_n, (out_valid && length == '0) |-> (angle == '0), "zero length with nonzero angle")

endmodule

bind segment_length_and_angle_top sla_checker u_sla_checker (.*);

// ===== test/segment_length_and_angle_top_test.sv =====
// testbench for segment_length_and_angle_top: directed and random segments with a
// cycle-free predictor of length and cordic angle, checked per output transaction
// depends on sla_pkg and segment_length_and_angle_top
`timescale 1ns / 1ps

module segment_length_and_angle_top_test;

    typedef struct packed {
        logic [sla_pkg::LEN_W-1:0]          len;
        logic signed [sla_pkg::ANGLE_W-1:0] ang;
        logic                               last;
    } polar_t;

    logic                                   clk = 1'b0;
    logic                                   rst_n = 1'b0;
    logic                                   in_valid = 1'b0;
    logic                                   in_ready;
    logic signed [sla_pkg::COORD_W-1:0]     start_x = '0;
    logic signed [sla_pkg::COORD_W-1:0]     start_y = '0;
    logic signed [sla_pkg::COORD_W-1:0]     end_x = '0;
    logic signed [sla_pkg::COORD_W-1:0]     end_y = '0;
    logic                                   last_in = 1'b0;
    logic                                   out_valid;
    logic                                   out_ready = 1'b0;
    logic [sla_pkg::LEN_W-1:0]              length;
    logic signed [sla_pkg::ANGLE_W-1:0]     angle;
    logic                                   last_out;

    polar_t expected_polar[$];
    int     mismatches = 0;
    int     send_idle_pct = 0;
    int     recv_idle_pct = 0;

    segment_length_and_angle_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .start_x   (start_x),
        .start_y   (start_y),
        .end_x     (end_x),
        .end_y     (end_y),
        .last_in   (last_in),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .length    (length),
        .angle     (angle),
        .last_out  (last_out)
    );

    always #5 clk = ~clk;

    // length rounded half up, angle from a vectoring cordic in 2^-16 rad, then rounded to 2^-13 rad
    function automatic polar_t polar_of_segment(
        input logic signed [sla_pkg::COORD_W-1:0] sx,
        input logic signed [sla_pkg::COORD_W-1:0] sy,
        input logic signed [sla_pkg::COORD_W-1:0] ex,
        input logic signed [sla_pkg::COORD_W-1:0] ey,
        input logic                               last
    );
        polar_t res;
        longint dx, dy, sum_sq, root, cand, x, y, z, xs, ys, t, step_ang;
        dx = longint'(ex) - longint'(sx);
        dy = longint'(ey) - longint'(sy);
        sum_sq = dx * dx + dy * dy;
        root = 0;
        for (int b = 17; b >= 0; b--)
        begin
            cand = root | (longint'(1) << b);
            if (cand * cand <= sum_sq)
                root = cand;
        end
        if (sum_sq - root * root > root)
            root = root + 1;
        if (dx == 0 && dy == 0)
            z = 0;
        else if (dy == 0 && dx < 0)
            z = sla_pkg::PI_Q13;
        else
        begin
            x = dx <<< sla_pkg::CORDIC_PRESHIFT;
            y = dy <<< sla_pkg::CORDIC_PRESHIFT;
            z = 0;
            // fold the left half plane onto the right one first
            if (x < 0)
            begin
                t = x;
                if (y >= 0)
                begin
                    x = y;
                    y = -t;
                    z = sla_pkg::HALF_PI_Q16;
                end
                else
                begin
                    x = -y;
                    y = t;
                    z = -sla_pkg::HALF_PI_Q16;
                end
            end
            for (int i = 0; i < sla_pkg::CORDIC_STEPS; i++)
            begin
                step_ang = longint'($rtoi($atan(2.0 ** (-i)) * 65536.0 + 0.5));
                xs = x >>> i;
                ys = y >>> i;
                if (y >= 0)
                begin
                    x = x + ys;
                    y = y - xs;
                    z = z + step_ang;
                end
                else
                begin
                    x = x - ys;
                    y = y + xs;
                    z = z - step_ang;
                end
            end
            z = (z + sla_pkg::Z_ROUND_BIAS) >>> sla_pkg::Z_ROUND_SHIFT;
            if (z > sla_pkg::PI_Q13)
                z = sla_pkg::PI_Q13;
            if (z < -sla_pkg::PI_Q13)
                z = -sla_pkg::PI_Q13;
        end
        res.len = sla_pkg::LEN_W'(root);
        res.ang = sla_pkg::ANGLE_W'(z);
        res.last = last;
        return res;
    endfunction

    function automatic logic signed [sla_pkg::COORD_W-1:0] clamp_coord(input int v);
        if (v > 32767)
            return 16'sd32767;
        if (v < -32768)
            return -16'sd32768;
        return sla_pkg::COORD_W'(v);
    endfunction

    function automatic logic signed [sla_pkg::COORD_W-1:0] extreme_coord();
        case ($urandom_range(4))
            0: return -16'sd32768;
            1: return -16'sd1;
            2: return 16'sd0;
            3: return 16'sd1;
            default: return 16'sd32767;
        endcase
    endfunction

    // receiver stalls
    always @(posedge clk)
        out_ready <= (int'($urandom_range(99)) >= recv_idle_pct);

    // score each output transaction, then predict each input transaction
    always @(posedge clk)
    begin
        polar_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_polar.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result: length=%0d angle=%0d last=%0b",
                                 length, angle, last_out);
                end
                else
                begin
                    want = expected_polar.pop_front();
                    if (length !== want.len || angle !== want.ang || last_out !== want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected length=%0d angle=%0d last=%0b, got length=%0d angle=%0d last=%0b",
                                     want.len, want.ang, want.last, length, angle, last_out);
                    end
                end
            end
            if (in_valid && in_ready)
                expected_polar.push_back(polar_of_segment(start_x, start_y, end_x, end_y,
                                                          last_in));
        end
    end

    // valid is left high after acceptance so back-to-back segments need no toggle
    task automatic send_segment(
        input logic signed [sla_pkg::COORD_W-1:0] sx,
        input logic signed [sla_pkg::COORD_W-1:0] sy,
        input logic signed [sla_pkg::COORD_W-1:0] ex,
        input logic signed [sla_pkg::COORD_W-1:0] ey,
        input logic                               last
    );
        if (int'($urandom_range(99)) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while (int'($urandom_range(99)) < send_idle_pct);
        end
        in_valid <= 1'b1;
        start_x <= sx;
        start_y <= sy;
        end_x <= ex;
        end_y <= ey;
        last_in <= last;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    // zero vector, both axes in both directions, diagonals, just off the negative x axis
    task automatic test_zero_and_axes();
        send_segment(0, 0, 0, 0, 1'b0);
        send_segment(-32768, -32768, -32768, -32768, 1'b1);
        send_segment(100, -100, 100, -100, 1'b0);
        send_segment(0, 0, -256, 0, 1'b0);
        send_segment(32767, 5, -32768, 5, 1'b1);
        send_segment(0, 0, 256, 0, 1'b0);
        send_segment(0, 0, 0, 256, 1'b0);
        send_segment(0, 0, 0, -256, 1'b1);
        send_segment(0, 0, 256, 256, 1'b0);
        send_segment(0, 0, -256, 256, 1'b0);
        send_segment(0, 0, -256, -256, 1'b0);
        send_segment(0, 0, 256, -256, 1'b1);
        send_segment(0, 0, -1000, 1, 1'b0);
        send_segment(0, 0, -1000, -1, 1'b0);
        send_segment(0, 0, -1, 0, 1'b1);
    endtask

    // longest segments and smallest nonzero ones, length rounding both ways
    task automatic test_coordinate_extremes();
        send_segment(-32768, -32768, 32767, 32767, 1'b0);
        send_segment(32767, 32767, -32768, -32768, 1'b1);
        send_segment(32767, -32768, -32768, 32767, 1'b0);
        send_segment(-32768, 32767, 32767, -32768, 1'b0);
        send_segment(0, 0, 1, 0, 1'b1);
        send_segment(0, 0, 0, 1, 1'b0);
        send_segment(0, 0, 1, 1, 1'b0);
        send_segment(0, 0, 2, 1, 1'b1);
        send_segment(0, 0, 2, 3, 1'b0);
    endtask

    task automatic test_random_segments(input int count);
        logic signed [sla_pkg::COORD_W-1:0] sx, sy, ex, ey;
        int shape;
        repeat (count)
        begin
            sx = sla_pkg::COORD_W'($urandom);
            sy = sla_pkg::COORD_W'($urandom);
            ex = sla_pkg::COORD_W'($urandom);
            ey = sla_pkg::COORD_W'($urandom);
            shape = $urandom_range(9);
            if (shape == 5 || shape == 6)
            begin
                // short segments near zero length and the axes
                ex = clamp_coord(int'(sx) + int'($urandom_range(64)) - 32);
                ey = clamp_coord(int'(sy) + int'($urandom_range(64)) - 32);
            end
            else if (shape == 7)
            begin
                if ($urandom_range(1))
                    ey = sy;
                else
                    ex = sx;
            end
            else if (shape == 8)
            begin
                sx = extreme_coord();
                sy = extreme_coord();
                ex = extreme_coord();
                ey = extreme_coord();
            end
            else if (shape == 9)
            begin
                ex = sx;
                ey = sy;
            end
            send_segment(sx, sy, ex, ey, 1'($urandom));
        end
    endtask

    initial
    begin
        repeat (7)
            @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct = 22;
        recv_idle_pct = 58;
        test_zero_and_axes();
        test_coordinate_extremes();
        test_random_segments(400);

        send_idle_pct = 58;
        recv_idle_pct = 22;
        test_random_segments(400);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_segments(400);

        in_valid <= 1'b0;
        while (expected_polar.size() != 0)
            @(posedge clk);
        repeat (40)
            @(posedge clk);

        if (mismatches == 0 && expected_polar.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        #20_000_000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule
